FILE: rtl/nmea_line_checksum_checker_top_macros.svh
// Assertion macros for the NMEA line checksum checker.
`ifndef NMEA_LINE_CHECKSUM_CHECKER_TOP_MACROS_SVH
`define NMEA_LINE_CHECKSUM_CHECKER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on the rising edge of i_clk outside reset.
`define NLCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("NLCC same-cycle check failed");
// Next-cycle implication, checked on the rising edge of i_clk outside reset.
`define NLCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("NLCC next-cycle check failed");
`else
`define NLCC_ASSERT_NOW(label, ante, cons)
`define NLCC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/nlcc_pkg.sv
// Constants, codes and helper functions of the NMEA line checksum checker.
`default_nettype none

package nlcc_pkg;

    localparam logic [7:0] BUF_SIZE   = 8'd128;
    localparam logic [7:0] SCAN_LIMIT = 8'd75;
    localparam logic [7:0] PREFIX_LEN = 8'd6;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [2:0] PH_DOLLAR = 3'd0;
    localparam logic [2:0] PH_BODY   = 3'd1;
    localparam logic [2:0] PH_HIGH   = 3'd2;
    localparam logic [2:0] PH_LOW    = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [2:0] FAIL_OK     = 3'd0;
    localparam logic [2:0] FAIL_DOLLAR = 3'd1;
    localparam logic [2:0] FAIL_LONG   = 3'd2;
    localparam logic [2:0] FAIL_STAR   = 3'd3;
    localparam logic [2:0] FAIL_SUM    = 3'd4;

    localparam logic [2:0] KIND_OTHER = 3'd0;
    localparam int         NUM_KINDS  = 5;

    // Sentence prefixes with the first character in the low byte.
    localparam logic [47:0] KIND_PREFIX [NUM_KINDS] = '{
        "AGGPG$",
        "CMRPG$",
        "LLGPG$",
        "GTVPG$",
        "AMRPG$"
    };

    typedef logic [7:0] t_byte;

    function automatic t_byte hex_digit(input logic [3:0] nib);
        t_byte digit;
        if (nib < 4'd10) begin
            digit = 8'h30 + {4'h0, nib};
        end else begin
            digit = 8'h37 + {4'h0, nib};
        end
        return digit;
    endfunction

    function automatic logic [2:0] classify(input logic [47:0] prefix);
        logic [2:0] kind;
        kind = KIND_OTHER;
        for (int k = NUM_KINDS - 1; k >= 0; k--) begin
            if (prefix == KIND_PREFIX[k]) begin
                kind = 3'(k + 1);
            end
        end
        return kind;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/nlcc_in_if.sv
// Channel that carries received bytes into the checker.
`default_nettype none

interface nlcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/nlcc_out_if.sv
// Channel that carries line verdicts out of the checker.
`default_nettype none

interface nlcc_out_if;
    logic       valid;
    logic       ready;
    logic       line_valid;
    logic [2:0] fail_kind;
    logic [7:0] xor_sum;
    logic [2:0] sentence_kind;
    logic [7:0] stored_length;

    modport source (output valid, output line_valid, output fail_kind, output xor_sum,
                    output sentence_kind, output stored_length, input ready);
    modport sink (input valid, input line_valid, input fail_kind, input xor_sum,
                  input sentence_kind, input stored_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/nmea_line_checksum_checker_top.sv
// Top level of the NMEA line checksum checker.
//
//   Channel  Dir  Interface    Word
//   i_rx     in   nlcc_in_if   one received byte (rx_byte)
//   o_res    out  nlcc_out_if  one verdict per line end
//
// One byte is taken every cycle except during the stall named below; the byte that ends a line yields its verdict.
// The byte passes an input register, then the per-line scan state and the result register.
// The only stall is a line end while the result register still holds an untaken verdict.
// Reset is synchronous and clears the scan state and both valid flags; no clearing pass is needed.
`default_nettype none
`include "nmea_line_checksum_checker_top_macros.svh"

module nmea_line_checksum_checker_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    nlcc_in_if.sink     i_rx,
    nlcc_out_if.source  o_res
);
    import nlcc_pkg::*;

    logic        r_s1_valid;
    t_byte       r_s1_byte;

    logic [7:0]  r_pos,    n_pos;
    logic [7:0]  r_xor,    n_xor;
    logic [2:0]  r_phase,  n_phase;
    logic [2:0]  r_fail,   n_fail;
    logic        r_hdm,    n_hdm;
    logic [47:0] r_prefix, n_prefix;

    logic        r_out_valid, n_out_valid;
    logic        r_out_line_valid, n_out_line_valid;
    logic [2:0]  r_out_fail, n_out_fail;
    logic [7:0]  r_out_xor, n_out_xor;
    logic [2:0]  r_out_kind, n_out_kind;
    logic [7:0]  r_out_len, n_out_len;

    logic        s1_ends;
    logic        out_free;
    logic        s1_go;
    logic [2:0]  end_fail;

    assign s1_ends  = (r_s1_byte == CH_NL) || (r_pos >= BUF_SIZE);
    assign out_free = !r_out_valid || o_res.ready;
    assign s1_go    = r_s1_valid && (!s1_ends || out_free);

    assign i_rx.ready = !r_s1_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_s1_valid <= i_rx.valid;
        end
        if (i_rx.ready) begin
            r_s1_byte <= i_rx.rx_byte;
        end
    end

    // The missing tail of a line reads as zero bytes, which settles any open phase.
    always_comb begin
        unique case (r_phase)
            PH_DOLLAR: end_fail = FAIL_DOLLAR;
            PH_BODY:   end_fail = (r_pos >= SCAN_LIMIT) ? FAIL_LONG : FAIL_STAR;
            PH_HIGH:   end_fail = FAIL_SUM;
            PH_LOW:    end_fail = FAIL_SUM;
            default:   end_fail = r_fail;
        endcase
    end

    always_comb begin
        n_pos    = r_pos;
        n_xor    = r_xor;
        n_phase  = r_phase;
        n_fail   = r_fail;
        n_hdm    = r_hdm;
        n_prefix = r_prefix;

        n_out_valid      = r_out_valid && !o_res.ready;
        n_out_line_valid = r_out_line_valid;
        n_out_fail       = r_out_fail;
        n_out_xor        = r_out_xor;
        n_out_kind       = r_out_kind;
        n_out_len        = r_out_len;

        if (s1_go) begin
            if (!s1_ends) begin
                if (r_pos < PREFIX_LEN) begin
                    n_prefix[{r_pos[2:0], 3'b000} +: 8] = r_s1_byte;
                end
                n_pos = r_pos + 8'd1;
                unique case (r_phase)
                    PH_DOLLAR: begin
                        if (r_s1_byte == CH_DOLLAR) begin
                            n_phase = PH_BODY;
                        end else begin
                            n_fail  = FAIL_DOLLAR;
                            n_phase = PH_DONE;
                        end
                    end
                    PH_BODY: begin
                        if (r_s1_byte != CH_NUL && r_s1_byte != CH_STAR
                                && r_pos < SCAN_LIMIT) begin
                            n_xor = r_xor ^ r_s1_byte;
                        end else if (r_pos >= SCAN_LIMIT) begin
                            n_fail  = FAIL_LONG;
                            n_phase = PH_DONE;
                        end else if (r_s1_byte == CH_STAR) begin
                            n_phase = PH_HIGH;
                        end else begin
                            n_fail  = FAIL_STAR;
                            n_phase = PH_DONE;
                        end
                    end
                    PH_HIGH: begin
                        n_hdm   = (r_s1_byte == hex_digit(r_xor[7:4]));
                        n_phase = PH_LOW;
                    end
                    PH_LOW: begin
                        n_fail  = (r_hdm && r_s1_byte == hex_digit(r_xor[3:0]))
                                  ? FAIL_OK : FAIL_SUM;
                        n_phase = PH_DONE;
                    end
                    default: begin
                    end
                endcase
            end else begin
                n_out_valid      = 1'b1;
                n_out_line_valid = (end_fail == FAIL_OK);
                n_out_fail       = end_fail;
                n_out_xor        = r_xor;
                n_out_kind       = (end_fail == FAIL_OK) ? classify(r_prefix) : KIND_OTHER;
                n_out_len        = r_pos;

                n_pos    = 8'd0;
                n_xor    = 8'd0;
                n_phase  = PH_DOLLAR;
                n_fail   = FAIL_OK;
                n_hdm    = 1'b0;
                n_prefix = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 8'd0;
            r_xor       <= 8'd0;
            r_phase     <= PH_DOLLAR;
            r_fail      <= FAIL_OK;
            r_hdm       <= 1'b0;
            r_prefix    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_xor       <= n_xor;
            r_phase     <= n_phase;
            r_fail      <= n_fail;
            r_hdm       <= n_hdm;
            r_prefix    <= n_prefix;
            r_out_valid <= n_out_valid;
        end
        r_out_line_valid <= n_out_line_valid;
        r_out_fail       <= n_out_fail;
        r_out_xor        <= n_out_xor;
        r_out_kind       <= n_out_kind;
        r_out_len        <= n_out_len;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.line_valid    = r_out_line_valid;
    assign o_res.fail_kind     = r_out_fail;
    assign o_res.xor_sum       = r_out_xor;
    assign o_res.sentence_kind = r_out_kind;
    assign o_res.stored_length = r_out_len;

    `NLCC_ASSERT_NOW(a_valid_matches_fail, r_out_valid, r_out_line_valid == (r_out_fail == FAIL_OK))
    `NLCC_ASSERT_NOW(a_kind_only_valid, r_out_valid && !r_out_line_valid, r_out_kind == KIND_OTHER)
    `NLCC_ASSERT_NOW(a_pos_bounded, 1'b1, r_pos <= BUF_SIZE)
    `NLCC_ASSERT_NOW(a_dollar_at_start, r_phase == PH_DOLLAR, r_pos == 8'd0 && r_xor == 8'd0)
    `NLCC_ASSERT_NEXT(a_line_end_gives_result, s1_go && s1_ends, r_out_valid)

endmodule

`default_nettype wire

FILE: sim/tb_nmea_line_checksum_checker_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the NMEA line checksum checker, with a line verdict scoreboard.

import nlcc_pkg::*;

typedef logic [7:0] t_octet;
typedef t_octet t_byte_q[$];

typedef struct packed {
    logic       line_valid;
    logic [2:0] fail_kind;
    logic [7:0] xor_sum;
    logic [2:0] sentence_kind;
    logic [7:0] stored_length;
} t_verdict;

typedef enum int {SUM_GOOD, SUM_BAD, SUM_LOWER, SUM_HALF, SUM_NONE, SUM_NOSTAR} t_sum_mode;

function automatic t_octet hex_char(input logic [3:0] nib, input bit lower);
    if (nib < 4'd10) begin
        return 8'h30 + {4'h0, nib};
    end
    return (lower ? 8'h57 : 8'h37) + {4'h0, nib};
endfunction

class verdict_scoreboard;
    int unsigned line_pos;
    t_octet      body_xor;
    logic [2:0]  phase;
    logic [2:0]  line_fail;
    bit          high_ok;
    logic [47:0] head_bytes;
    t_verdict    expected_q[$];
    int          mismatches;

    function new();
        mismatches = 0;
        clear_line();
    endfunction

    function void clear_line();
        line_pos   = 0;
        body_xor   = 8'h00;
        phase      = PH_DOLLAR;
        line_fail  = FAIL_OK;
        high_ok    = 1'b0;
        head_bytes = '0;
    endfunction

    function void scan(input t_octet b, input int unsigned at);
        case (phase)
            PH_DOLLAR: begin
                if (b == CH_DOLLAR) begin
                    phase = PH_BODY;
                end else begin
                    line_fail = FAIL_DOLLAR;
                    phase = PH_DONE;
                end
            end
            PH_BODY: begin
                if (b != CH_NUL && b != CH_STAR && at < SCAN_LIMIT) begin
                    body_xor ^= b;
                end else if (at >= SCAN_LIMIT) begin
                    line_fail = FAIL_LONG;
                    phase = PH_DONE;
                end else if (b == CH_STAR) begin
                    phase = PH_HIGH;
                end else begin
                    line_fail = FAIL_STAR;
                    phase = PH_DONE;
                end
            end
            PH_HIGH: begin
                high_ok = (b == hex_char(body_xor[7:4], 1'b0));
                phase = PH_LOW;
            end
            PH_LOW: begin
                line_fail = (high_ok && b == hex_char(body_xor[3:0], 1'b0)) ? FAIL_OK : FAIL_SUM;
                phase = PH_DONE;
            end
            default: begin
            end
        endcase
    endfunction

    function logic [2:0] kind_of();
        string names[5] = '{"$GPGGA", "$GPRMC", "$GPGLL", "$GPVTG", "$GPRMA"};
        bit    same;
        for (int k = 0; k < 5; k++) begin
            same = 1'b1;
            for (int j = 0; j < 6; j++) begin
                if (head_bytes[8*j +: 8] != names[k][j]) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                return 3'(k + 1);
            end
        end
        return KIND_OTHER;
    endfunction

    function void note_byte(input t_octet b);
        t_verdict v;
        if (b != CH_NL && line_pos < BUF_SIZE) begin
            if (line_pos < 6) begin
                head_bytes[8*line_pos +: 8] = b;
            end
            scan(b, line_pos);
            line_pos++;
            return;
        end
        // The unstored rest of the line reads as zero bytes.
        for (int k = 0; k < 3 && phase != PH_DONE; k++) begin
            scan(CH_NUL, line_pos + k);
        end
        v.fail_kind     = line_fail;
        v.line_valid    = (line_fail == FAIL_OK);
        v.xor_sum       = body_xor;
        v.sentence_kind = v.line_valid ? kind_of() : KIND_OTHER;
        v.stored_length = line_pos[7:0];
        expected_q.push_back(v);
        clear_line();
    endfunction

    function void check_verdict(input t_verdict got);
        t_verdict want;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Unexpected verdict: valid=%0d fail=%0d xor=%02h kind=%0d len=%0d",
                         got.line_valid, got.fail_kind, got.xor_sum, got.sentence_kind,
                         got.stored_length);
            end
            return;
        end
        want = expected_q.pop_front();
        if (want.line_valid !== got.line_valid || want.fail_kind !== got.fail_kind ||
            want.xor_sum !== got.xor_sum || want.sentence_kind !== got.sentence_kind ||
            want.stored_length !== got.stored_length) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Mismatch: expected valid=%0d fail=%0d xor=%02h kind=%0d len=%0d",
                         want.line_valid, want.fail_kind, want.xor_sum, want.sentence_kind,
                         want.stored_length);
                $display("          actual   valid=%0d fail=%0d xor=%02h kind=%0d len=%0d",
                         got.line_valid, got.fail_kind, got.xor_sum, got.sentence_kind,
                         got.stored_length);
            end
        end
    endfunction
endclass

module tb_nmea_line_checksum_checker_top;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   steady_tx;
    bit   steady_rx;
    int   sent_total = 0;

    nlcc_in_if  rx_ch ();
    nlcc_out_if res_ch ();

    verdict_scoreboard sb = new();

    string heads[6] = '{"GPGGA,", "GPRMC,", "GPGLL,", "GPVTG,", "GPRMA,", "GPGSA,"};

    nmea_line_checksum_checker_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_byte_q sentence(input string head, input int tail_len,
                                         input t_sum_mode mode);
        t_byte_q q;
        t_octet  x;
        t_octet  c;
        x = 8'h00;
        q.push_back(CH_DOLLAR);
        for (int i = 0; i < head.len(); i++) begin
            q.push_back(head[i]);
            x ^= head[i];
        end
        for (int i = 0; i < tail_len; i++) begin
            c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                            : 8'($urandom_range(32, 126));
            if (c == CH_STAR) begin
                c = 8'h2C;
            end
            q.push_back(c);
            x ^= c;
        end
        if (mode != SUM_NOSTAR) begin
            q.push_back(CH_STAR);
        end
        case (mode)
            SUM_GOOD: begin
                q.push_back(hex_char(x[7:4], 1'b0));
                q.push_back(hex_char(x[3:0], 1'b0));
            end
            SUM_BAD: begin
                q.push_back(hex_char(x[7:4], 1'b0));
                q.push_back(hex_char(x[3:0] + 4'd1, 1'b0));
            end
            SUM_LOWER: begin
                q.push_back(hex_char(x[7:4], 1'b1));
                q.push_back(hex_char(x[3:0], 1'b1));
            end
            SUM_HALF: begin
                q.push_back(hex_char(x[7:4], 1'b0));
            end
            default: begin
            end
        endcase
        q.push_back(CH_NL);
        return q;
    endfunction

    task automatic send_byte(input t_octet b);
        int gap;
        gap = steady_tx ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!(rx_ch.valid && rx_ch.ready));
        sb.note_byte(b);
    endtask

    task automatic send_line(input t_byte_q q);
        steady_tx = ($urandom_range(0, 5) == 0);
        foreach (q[i]) begin
            send_byte(q[i]);
        end
        sent_total += q.size();
    endtask

    task automatic drain_verdicts();
        rx_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0);
    endtask

    initial begin
        t_verdict got;
        wait (i_rst_n === 1'b1);
        forever begin
            int stall;
            stall = steady_rx ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
            got.line_valid    = res_ch.line_valid;
            got.fail_kind     = res_ch.fail_kind;
            got.xor_sum       = res_ch.xor_sum;
            got.sentence_kind = res_ch.sentence_kind;
            got.stored_length = res_ch.stored_length;
            sb.check_verdict(got);
            if ($urandom_range(0, 15) == 0) begin
                steady_rx = ~steady_rx;
            end
        end
    end

    initial begin
        t_byte_q line_q;
        int      pick;
        bit      drained;
        i_rst_n       <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        res_ch.ready  <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        line_q = {CH_NL};
        send_line(line_q);
        line_q = {8'h00, 8'hFF, CH_NL};
        send_line(line_q);
        send_line(sentence("GPGGA,123519,4807.038,N", 0, SUM_GOOD));
        send_line(sentence("GPRMC,A", 0, SUM_GOOD));
        send_line(sentence("GPGLL,B", 0, SUM_GOOD));
        send_line(sentence("GPVTG,1", 0, SUM_GOOD));
        send_line(sentence("GPRMA,X", 0, SUM_GOOD));
        send_line(sentence("GPGSA,A,3", 0, SUM_GOOD));
        send_line(sentence("Z", 0, SUM_GOOD));
        send_line(sentence("GPGGA,7", 0, SUM_BAD));
        send_line(sentence("Z", 0, SUM_LOWER));
        send_line(sentence("AB", 0, SUM_NONE));
        send_line(sentence("AB", 0, SUM_HALF));
        send_line(sentence("GPGGA,1", 0, SUM_NOSTAR));
        send_line(sentence("", 0, SUM_NOSTAR));
        line_q = {CH_DOLLAR, 8'h47, CH_NUL, CH_STAR, 8'h34, 8'h37, CH_NL};
        send_line(line_q);
        send_line(sentence("", 80, SUM_GOOD));
        send_line(sentence("", 74, SUM_GOOD));
        send_line(sentence("", 73, SUM_GOOD));
        line_q = sentence("GPGLL,Q", 0, SUM_GOOD);
        line_q.insert(line_q.size() - 1, 8'hFF);
        line_q.insert(line_q.size() - 1, 8'h0D);
        send_line(line_q);
        send_line(sentence("", 124, SUM_GOOD));
        send_line(sentence("", 200, SUM_GOOD));

        drain_verdicts();

        drained = 1'b0;
        while (sent_total < 1800) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                line_q = sentence(heads[$urandom_range(0, 5)],
                                  ($urandom_range(0, 9) == 0) ? $urandom_range(41, 80)
                                                              : $urandom_range(0, 40),
                                  ($urandom_range(0, 9) < 6) ? SUM_GOOD
                                                             : t_sum_mode'($urandom_range(1, 5)));
                if ($urandom_range(0, 3) == 0) begin
                    line_q.insert(line_q.size() - 1, 8'h0D);
                end
            end else if (pick < 85) begin
                line_q.delete();
                repeat ($urandom_range(0, 20)) line_q.push_back(8'($urandom_range(0, 255)));
                line_q.push_back(CH_NL);
            end else if (pick < 95) begin
                line_q = sentence(heads[$urandom_range(0, 5)], $urandom_range(0, 30), SUM_GOOD);
                line_q[$urandom_range(0, line_q.size() - 2)] = 8'($urandom_range(0, 255));
            end else begin
                line_q = sentence("", $urandom_range(120, 140), SUM_GOOD);
            end
            send_line(line_q);
            if (!drained && sent_total >= 900) begin
                drained = 1'b1;
                drain_verdicts();
            end
        end

        rx_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
